FILE: rtl/qphdp_pkg.sv
// Shared constants, tables and controller/datapath interface types for the hull DP block.
package qphdp_pkg;

  localparam int HULL_DEPTH = 1024;
  localparam int ADDR_W     = $clog2(HULL_DEPTH);
  localparam int TAIL_W     = ADDR_W + 1;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_A = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_B = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_C = 2'd2;

  // operand select of the shared multiplier; also names where the product lands
  localparam logic [3:0] MS_AS   = 4'd0;
  localparam logic [3:0] MS_ASS  = 4'd1;
  localparam logic [3:0] MS_BS   = 4'd2;
  localparam logic [3:0] MS_NM   = 4'd3;
  localparam logic [3:0] MS_F0   = 4'd4;
  localparam logic [3:0] MS_F1   = 4'd5;
  localparam logic [3:0] MS_BEST = 4'd6;
  localparam logic [3:0] MS_P    = 4'd7;
  localparam logic [3:0] MS_Q    = 4'd8;

  // 32x32 partial products in order; the first three give a 64-bit result
  localparam int MUL_STEPS  = 10;
  localparam int MUL_NARROW = 3;
  localparam logic [1:0] MUL_I [MUL_STEPS] = '{2'd0, 2'd0, 2'd1, 2'd0, 2'd1,
                                              2'd2, 2'd0, 2'd1, 2'd2, 2'd3};
  localparam logic [1:0] MUL_J [MUL_STEPS] = '{2'd0, 2'd1, 2'd0, 2'd2, 2'd1,
                                              2'd0, 2'd3, 2'd2, 2'd1, 2'd0};

  typedef struct packed {
    logic              load_in;
    logic              restart;
    logic              mul_start;
    logic [3:0]        mul_sel;
    logic              prep;
    logic              calc_nk;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr_a;
    logic [ADDR_W-1:0] rd_addr_b;
    logic              out_load;
    logic              ovf;
  } qph_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic front_pop;
    logic d1_zero;
    logic d2_zero;
    logic back_drop;
  } qph_stat_t;

endpackage

FILE: rtl/qphdp_mul.sv
// Multi-cycle 128-bit modular multiplier built on one 32x32 multiplier.
module qphdp_mul
  import qphdp_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic         wide,
  input  logic [127:0] x,
  input  logic [127:0] y,
  output logic         done,
  output logic [127:0] prod
);

  logic [127:0] xr, yr, acc;
  logic [3:0]   step, last;
  logic         busy;
  logic [1:0]   pi, pj;
  logic [63:0]  pp;
  logic [7:0]   sh;

  always_comb begin
    pi = MUL_I[step];
    pj = MUL_J[step];
    pp = 64'(xr[{pi, 5'b0} +: 32]) * 64'(yr[{pj, 5'b0} +: 32]);
    sh = {3'b0, 3'({1'b0, pi} + {1'b0, pj}), 2'b0} << 3;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && step == last) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      xr   <= x;
      yr   <= y;
      acc  <= '0;
      step <= '0;
      last <= wide ? 4'(MUL_STEPS - 1) : 4'(MUL_NARROW - 1);
    end else if (busy) begin
      acc  <= acc + (128'(pp) << sh);
      step <= step + 4'd1;
    end
  end

  assign prod = acc;

endmodule

FILE: rtl/qphdp_datapath.sv
// Datapath: coefficients, prefix sum, line store, multiplier operands and result registers.
module qphdp_datapath
  import qphdp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  qph_cmd_t              cmd,
  output qph_stat_t             stat,
  input  logic [9:0]            element_value,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic [63:0]           best_score,
  output logic                  hull_overflow
);

  logic signed [10:0] coef_a;
  logic [31:0]        coef_b, coef_c;
  logic [31:0]        prefix_sum;

  logic [63:0] slope_mem [HULL_DEPTH];
  logic [63:0] icpt_mem  [HULL_DEPTH];
  logic [63:0] m_ra, k_ra, m_rb, k_rb;
  logic        zero_a, zero_b;
  logic [63:0] ma, ka, mb, kb;

  logic [63:0]  ass, bs, nm, nk, f0, f1, dp;
  logic [127:0] p, q, n1r, n2r;
  logic [63:0]  dy1, dy2;
  logic         d1z, d2z;
  logic [3:0]   sel_q;

  logic [127:0] mx, my, prod;
  logic         mdone;
  logic [127:0] ax, sx;
  logic [63:0]  d1, d2;
  logic [127:0] n1, n2;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_a     <= -11'sd1;
      coef_b     <= '0;
      coef_c     <= '0;
      prefix_sum <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_COEF_A: coef_a <= cfg_data[10:0];
          REG_COEF_B: coef_b <= cfg_data;
          REG_COEF_C: coef_c <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.load_in)
        prefix_sum <= (cmd.restart ? 32'd0 : prefix_sum) + 32'(element_value);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      slope_mem[cmd.wr_addr] <= nm;
      icpt_mem[cmd.wr_addr]  <= nk;
    end
    m_ra   <= slope_mem[cmd.rd_addr_a];
    k_ra   <= icpt_mem[cmd.rd_addr_a];
    m_rb   <= slope_mem[cmd.rd_addr_b];
    k_rb   <= icpt_mem[cmd.rd_addr_b];
    zero_a <= cmd.rd_addr_a == '0;
    zero_b <= cmd.rd_addr_b == '0;
  end

  // entry 0 is always the initial zero line
  assign ma = zero_a ? 64'd0 : m_ra;
  assign ka = zero_a ? 64'd0 : k_ra;
  assign mb = zero_b ? 64'd0 : m_rb;
  assign kb = zero_b ? 64'd0 : k_rb;

  assign ax = {{117{coef_a[10]}}, coef_a};
  assign sx = {96'd0, prefix_sum};

  always_comb begin
    unique case (cmd.mul_sel)
      MS_AS:   begin mx = ax;                      my = sx; end
      MS_ASS:  begin mx = {64'd0, ass};            my = sx; end
      MS_BS:   begin mx = {{96{coef_b[31]}}, coef_b}; my = sx; end
      MS_NM:   begin mx = 128'd0 - (ax << 1);      my = sx; end
      MS_F0:   begin mx = {64'd0, ma};             my = sx; end
      MS_F1:   begin mx = {64'd0, mb};             my = sx; end
      MS_BEST: begin mx = {64'd0, ma};             my = sx; end
      MS_P:    begin mx = n2r; my = {{64{dy1[63]}}, dy1}; end
      MS_Q:    begin mx = n1r; my = {{64{dy2[63]}}, dy2}; end
      default: begin mx = '0;                      my = '0; end
    endcase
  end

  qphdp_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.mul_start),
    .wide  (cmd.mul_sel == MS_P || cmd.mul_sel == MS_Q),
    .x     (mx),
    .y     (my),
    .done  (mdone),
    .prod  (prod)
  );

  always_comb begin
    d1 = ma - mb;
    d2 = mb - nm;
    n1 = {{64{kb[63]}}, kb} - {{64{ka[63]}}, ka};
    n2 = {{64{nk[63]}}, nk} - {{64{kb[63]}}, kb};
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_start) sel_q <= cmd.mul_sel;
    if (mdone) begin
      unique case (sel_q)
        MS_AS, MS_ASS: ass <= prod[63:0];
        MS_BS:   bs <= prod[63:0];
        MS_NM:   nm <= prod[63:0];
        MS_F0:   f0 <= prod[63:0] + ka;
        MS_F1:   f1 <= prod[63:0] + kb;
        MS_BEST: dp <= ass + bs + {{32{coef_c[31]}}, coef_c} + prod[63:0] + ka;
        MS_P:    p <= prod;
        MS_Q:    q <= prod;
        default: ;
      endcase
    end
    if (cmd.calc_nk) nk <= dp + ass - bs;
    if (cmd.prep) begin
      d1z <= d1 == '0;
      d2z <= d2 == '0;
      dy1 <= d1[63] ? 64'd0 - d1 : d1;
      n1r <= d1[63] ? 128'd0 - n1 : n1;
      dy2 <= d2[63] ? 64'd0 - d2 : d2;
      n2r <= d2[63] ? 128'd0 - n2 : n2;
    end
    if (cmd.out_load) begin
      best_score    <= dp;
      hull_overflow <= cmd.ovf;
    end
  end

  assign stat.mul_done  = mdone;
  assign stat.front_pop = $signed(f0) <= $signed(f1);
  assign stat.d1_zero   = d1z;
  assign stat.d2_zero   = d2z;
  assign stat.back_drop = $signed(p) <= $signed(q);

endmodule

FILE: rtl/qphdp_ctrl.sv
// Controller: item handshake, deque head and tail, and the step sequence of one item.
module qphdp_ctrl
  import qphdp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic      in_start,
  output logic      out_valid,
  input  logic      out_ready,
  output qph_cmd_t  cmd,
  input  qph_stat_t stat
);

  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_A1    = 5'd1;
  localparam logic [4:0] ST_A2    = 5'd2;
  localparam logic [4:0] ST_B     = 5'd3;
  localparam logic [4:0] ST_N     = 5'd4;
  localparam logic [4:0] ST_FCHK  = 5'd5;
  localparam logic [4:0] ST_FRD   = 5'd6;
  localparam logic [4:0] ST_F0    = 5'd7;
  localparam logic [4:0] ST_F1    = 5'd8;
  localparam logic [4:0] ST_FCMP  = 5'd9;
  localparam logic [4:0] ST_BRD   = 5'd10;
  localparam logic [4:0] ST_BEST  = 5'd11;
  localparam logic [4:0] ST_NK    = 5'd12;
  localparam logic [4:0] ST_KCHK  = 5'd13;
  localparam logic [4:0] ST_KRD   = 5'd14;
  localparam logic [4:0] ST_KPREP = 5'd15;
  localparam logic [4:0] ST_KDEC  = 5'd16;
  localparam logic [4:0] ST_KQ    = 5'd17;
  localparam logic [4:0] ST_KCMP  = 5'd18;
  localparam logic [4:0] ST_WR    = 5'd19;
  localparam logic [4:0] ST_OUT   = 5'd20;
  localparam logic [4:0] ST_MWAIT = 5'd21;

  logic [4:0]        state, state_next, ret, ret_next;
  logic [ADDR_W-1:0] head, head_next;
  logic [TAIL_W-1:0] tail, tail_next, occ;
  logic              ovf, ovf_next, back, back_next, ovalid_next;

  assign occ      = tail - {1'b0, head};
  assign in_ready = state == ST_IDLE;

  always_comb begin
    state_next  = state;
    ret_next    = ret;
    head_next   = head;
    tail_next   = tail;
    ovf_next    = ovf;
    back_next   = back;
    ovalid_next = out_valid && !out_ready;
    cmd           = '0;
    cmd.restart   = in_start;
    cmd.wr_addr   = tail[ADDR_W-1:0];
    cmd.rd_addr_a = back ? ADDR_W'(tail - TAIL_W'(2)) : head;
    cmd.rd_addr_b = back ? ADDR_W'(tail - TAIL_W'(1)) : ADDR_W'(head + 1'b1);
    cmd.ovf       = ovf;
    unique case (state)
      ST_IDLE: begin
        back_next = 1'b0;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          if (in_start) begin
            head_next = '0;
            tail_next = TAIL_W'(1);
            ovf_next  = 1'b0;
          end
          state_next = ST_A1;
        end
      end
      ST_A1: begin
        cmd.mul_start = 1'b1; cmd.mul_sel = MS_AS;
        ret_next = ST_A2; state_next = ST_MWAIT;
      end
      ST_A2: begin
        cmd.mul_start = 1'b1; cmd.mul_sel = MS_ASS;
        ret_next = ST_B; state_next = ST_MWAIT;
      end
      ST_B: begin
        cmd.mul_start = 1'b1; cmd.mul_sel = MS_BS;
        ret_next = ST_N; state_next = ST_MWAIT;
      end
      ST_N: begin
        cmd.mul_start = 1'b1; cmd.mul_sel = MS_NM;
        ret_next = ST_FCHK; state_next = ST_MWAIT;
      end
      ST_FCHK: state_next = (occ >= TAIL_W'(2)) ? ST_FRD : ST_BRD;
      ST_FRD:  state_next = ST_F0;
      ST_F0: begin
        cmd.mul_start = 1'b1; cmd.mul_sel = MS_F0;
        ret_next = ST_F1; state_next = ST_MWAIT;
      end
      ST_F1: begin
        cmd.mul_start = 1'b1; cmd.mul_sel = MS_F1;
        ret_next = ST_FCMP; state_next = ST_MWAIT;
      end
      ST_FCMP: begin
        if (stat.front_pop) begin
          head_next  = head + 1'b1;
          state_next = ST_FCHK;
        end else begin
          state_next = ST_BEST;
        end
      end
      ST_BRD: state_next = ST_BEST;
      ST_BEST: begin
        cmd.mul_start = 1'b1; cmd.mul_sel = MS_BEST;
        ret_next = ST_NK; state_next = ST_MWAIT;
      end
      ST_NK: begin
        cmd.calc_nk = 1'b1;
        back_next   = 1'b1;
        state_next  = ST_KCHK;
      end
      ST_KCHK:  state_next = (occ >= TAIL_W'(2)) ? ST_KRD : ST_WR;
      ST_KRD:   state_next = ST_KPREP;
      ST_KPREP: begin
        cmd.prep   = 1'b1;
        state_next = ST_KDEC;
      end
      ST_KDEC: begin
        priority if (stat.d1_zero) begin
          tail_next  = tail - 1'b1;
          state_next = ST_KCHK;
        end else if (stat.d2_zero) begin
          state_next = ST_WR;
        end else begin
          cmd.mul_start = 1'b1; cmd.mul_sel = MS_P;
          ret_next = ST_KQ; state_next = ST_MWAIT;
        end
      end
      ST_KQ: begin
        cmd.mul_start = 1'b1; cmd.mul_sel = MS_Q;
        ret_next = ST_KCMP; state_next = ST_MWAIT;
      end
      ST_KCMP: begin
        if (stat.back_drop) begin
          tail_next  = tail - 1'b1;
          state_next = ST_KCHK;
        end else begin
          state_next = ST_WR;
        end
      end
      ST_WR: begin
        if (tail < TAIL_W'(HULL_DEPTH)) begin
          cmd.wr_en = 1'b1;
          tail_next = tail + 1'b1;
        end else begin
          ovf_next = 1'b1;
        end
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          ovalid_next  = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      ST_MWAIT: if (stat.mul_done) state_next = ret;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      ret       <= ST_IDLE;
      head      <= '0;
      tail      <= TAIL_W'(1);
      ovf       <= 1'b0;
      back      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      ret       <= ret_next;
      head      <= head_next;
      tail      <= tail_next;
      ovf       <= ovf_next;
      back      <= back_next;
      out_valid <= ovalid_next;
    end
  end

`ifndef SYNTHESIS
  a_head_below_tail: assert property (@(posedge clk) disable iff (rst)
    tail > {1'b0, head}) else $error("deque head passed tail");
  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_en |-> tail < TAIL_W'(HULL_DEPTH)) else $error("line write past end");
  a_done_when_waiting: assert property (@(posedge clk) disable iff (rst)
    stat.mul_done |-> state == ST_MWAIT) else $error("product finished unawaited");
  a_start_idle_only: assert property (@(posedge clk) disable iff (rst)
    cmd.load_in |=> state != ST_IDLE) else $error("item not taken up");
`endif

endmodule

FILE: rtl/quadratic_partition_hull_dp.sv
// Top level of the quadratic partition score block (convex hull trick, monotone deque).
//
// Input beats carry one element value; tuser marks the first element of a new sequence,
// which clears the prefix sum, the overflow flag and the deque before the element.
// Each input beat yields exactly one output beat: the best score so far and the sticky
// overflow flag, set when the 1024-line deque is full and a new line is dropped.
// Coefficients must be written via cfg_we/cfg_index/cfg_data while the block is idle;
// the block itself does not enforce this. Every product runs on one shared 32x32
// multiplier: a front comparison runs two 64-bit products, a back comparison two
// 128-bit products unless two slopes are equal. One item is in work at a time.
// The result sits in an output register; the next item is taken while it waits, and the
// block holds before issuing the following result until the receiver takes it.
// Reset (rst, synchronous) empties the pipeline and restores coefficients a=-1, b=0, c=0
// and a deque holding only the zero line. The line store needs no clearing pass.
module quadratic_partition_hull_dp
  import qphdp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [15:0]           s_tdata,   // [9:0] element_value, rest zero
  input  logic [0:0]            s_tuser,   // [0] start_new
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [63:0]           m_tdata,   // [63:0] best_score
  output logic [0:0]            m_tuser,   // [0] hull_overflow
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  qph_cmd_t  cmd;
  qph_stat_t stat;

  qphdp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_start  (s_tuser[0]),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .cmd       (cmd),
    .stat      (stat)
  );

  qphdp_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .element_value (s_tdata[9:0]),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .best_score    (m_tdata),
    .hull_overflow (m_tuser[0])
  );

endmodule

FILE: verif/qphdp_checker.sv
// Hull DP checker: watches all channels, predicts each score and compares the results.
`timescale 1ns / 100ps
module qphdp_checker
  import qphdp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [15:0]           s_tdata,   // [9:0] element_value
  input  logic [0:0]            s_tuser,   // [0] start_new
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [63:0]           m_tdata,   // [63:0] best_score
  input  logic [0:0]            m_tuser,   // [0] hull_overflow
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    errors,
  output int                    pending,
  output int                    results,
  output int                    overflows
);
  logic [63:0] coef_a, coef_b, coef_c;
  logic [31:0] psum;
  logic [63:0] slope_mem [HULL_DEPTH];
  logic [63:0] icpt_mem [HULL_DEPTH];
  int unsigned head, tail;
  bit          ovf_seen;
  logic [63:0] score_q [$];
  bit          ovf_q [$];

  function automatic bit hull_drop(logic [63:0] m1, k1, m2, k2, mn, kn);
    logic signed [127:0] d1, d2, n1, n2;
    d1 = $signed(m1) - $signed(m2);
    d2 = $signed(m2) - $signed(mn);
    if (d1 == 0) return 1'b1;
    if (d2 == 0) return 1'b0;
    n1 = $signed(k2) - $signed(k1);
    n2 = $signed(kn) - $signed(k2);
    if (d1 < 0) begin
      d1 = -d1;
      n1 = -n1;
    end
    if (d2 < 0) begin
      d2 = -d2;
      n2 = -n2;
    end
    return (n2 * d1) <= (n1 * d2);
  endfunction

  function automatic void restart_seq();
    psum = '0;
    head = 0;
    tail = 1;
    slope_mem[0] = '0;
    icpt_mem[0] = '0;
    ovf_seen = 1'b0;
  endfunction

  function automatic void predict_score(logic [9:0] v, bit st);
    logic [63:0] s, ass, bs, f0, f1, best, dp, nm, nk;
    if (st) restart_seq();
    psum = psum + {22'd0, v};
    s = {32'd0, psum};
    ass = coef_a * s * s;
    bs = coef_b * s;
    while (tail - head >= 2) begin
      f0 = slope_mem[head] * s + icpt_mem[head];
      f1 = slope_mem[head + 1] * s + icpt_mem[head + 1];
      if ($signed(f0) > $signed(f1)) break;
      head++;
    end
    best = slope_mem[head] * s + icpt_mem[head];
    dp = ass + bs + coef_c + best;
    nm = (64'd0 - 64'd2 * coef_a) * s;
    nk = dp + ass - bs;
    while (tail - head >= 2 && hull_drop(slope_mem[tail - 2], icpt_mem[tail - 2],
                                         slope_mem[tail - 1], icpt_mem[tail - 1], nm, nk))
      tail--;
    if (tail < HULL_DEPTH) begin
      slope_mem[tail] = nm;
      icpt_mem[tail] = nk;
      tail++;
    end else begin
      ovf_seen = 1'b1;
    end
    score_q.insert(score_q.size(), dp);
    ovf_q.insert(ovf_q.size(), ovf_seen);
  endfunction

  initial begin
    errors = 0;
    results = 0;
    overflows = 0;
    coef_a = '1;
    coef_b = '0;
    coef_c = '0;
    restart_seq();
  end

  assign pending = score_q.size();

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_we) begin
        case (cfg_index)
          REG_COEF_A: coef_a = {{53{cfg_data[10]}}, cfg_data[10:0]};
          REG_COEF_B: coef_b = {{32{cfg_data[31]}}, cfg_data};
          REG_COEF_C: coef_c = {{32{cfg_data[31]}}, cfg_data};
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) predict_score(s_tdata[9:0], s_tuser[0]);
      if (m_tvalid && m_tready) begin
        results++;
        if (m_tuser[0]) overflows++;
        if (score_q.size() == 0) begin
          $display("%0t: unexpected result beat score=%0d ovf=%0b", $time,
                   $signed(m_tdata), m_tuser[0]);
          errors++;
        end else begin
          if (m_tdata !== score_q[0]) begin
            $display("%0t: best_score expected %0d actual %0d", $time,
                     $signed(score_q[0]), $signed(m_tdata));
            errors++;
          end
          if (m_tuser[0] !== ovf_q[0]) begin
            $display("%0t: hull_overflow expected %0b actual %0b", $time,
                     ovf_q[0], m_tuser[0]);
            errors++;
          end
          score_q.delete(0);
          ovf_q.delete(0);
        end
      end
    end
  end
endmodule

FILE: verif/quadratic_partition_hull_dp_tb.sv
// Testbench top for the hull DP block: clock, reset, stimulus, back-pressure and verdict.
`timescale 1ns / 100ps
module quadratic_partition_hull_dp_tb;
  import qphdp_pkg::*;

  localparam int IDLE_LIMIT = 200000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [15:0]           s_tdata = '0;
  logic [0:0]            s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [63:0]           m_tdata;
  logic [0:0]            m_tuser;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int                    errors, pending, results, overflows;
  bit                    hold_req = 1'b0;
  int                    phases = 0;

  quadratic_partition_hull_dp dut (.*);

  qphdp_checker chk (.clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser, .m_tvalid,
                     .m_tready, .m_tdata, .m_tuser, .cfg_we, .cfg_index, .cfg_data,
                     .errors, .pending, .results, .overflows);

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  task automatic send_element(logic [9:0] v, bit st, bit gaps);
    int g;
    g = gaps ? pick_gap() : 0;
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {6'd0, v};
    s_tuser <= st;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_coefs(logic [31:0] a, logic [31:0] b, logic [31:0] c);
    cfg_we <= 1'b1;
    cfg_index <= REG_COEF_A;
    cfg_data <= a;
    @(negedge clk);
    cfg_index <= REG_COEF_B;
    cfg_data <= b;
    @(negedge clk);
    cfg_index <= REG_COEF_C;
    cfg_data <= c;
    @(negedge clk);
    cfg_we <= 1'b0;
    phases++;
  endtask

  function automatic logic [9:0] rand_element();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return 10'($urandom_range(1, 15));
    if (r < 5) return 10'd1023;
    return 10'($urandom_range(1, 1023));
  endfunction

  // receiver: random stalls, one long hold-off on request
  initial begin
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (700) @(negedge clk);
        hold_req = 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat (pick_gap() + 1) @(negedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(negedge clk);
      end
    end
  end

  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst) idle = 0;
      else idle++;
      if (idle >= IDLE_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    int len;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: reset coefficients, then field extremes and restarts
    send_element(10'd1, 1'b0, 1'b0);
    send_element(10'd1023, 1'b0, 1'b0);
    send_element(10'd1023, 1'b0, 1'b0);
    send_element(10'd1, 1'b1, 1'b0);
    send_element(10'd512, 1'b0, 1'b0);
    send_element(10'd341, 1'b0, 1'b0);
    drain();
    write_coefs(32'h0000_0400, 32'h7FFF_FFFF, 32'h8000_0000);
    for (int i = 0; i < 6; i++) send_element(i[0] ? 10'd1023 : 10'd1, i == 0, 1'b0);
    drain();
    write_coefs(32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    for (int i = 0; i < 6; i++) send_element(10'(1 << i), i == 3, 1'b0);
    drain();
    // coefficient a of zero and positive
    write_coefs(32'h0000_0000, 32'h0000_0005, 32'hFFFF_FFF0);
    for (int i = 0; i < 3; i++) send_element(10'd7, i == 0, 1'b0);
    drain();
    write_coefs(32'hFFFF_F3FF, 32'h0000_0000, 32'h0000_0000);
    for (int i = 0; i < 3; i++) send_element(10'd300, i == 0, 1'b0);
    drain();

    // random phases
    for (int p = 0; p < 8; p++) begin
      if (p == 7) write_coefs(32'hFFFF_FFFF, 32'd0, 32'd0);
      else if ($urandom_range(0, 7) == 0) write_coefs($urandom, $urandom, $urandom);
      else write_coefs(32'($urandom_range(1024, 2047)), $urandom, $urandom);
      if (p == 1) hold_req = 1'b1;
      if (p == 7) begin
        // one long sequence of small values
        for (int i = 0; i < 110; i++) send_element(10'($urandom_range(1, 3)), i == 0, 1'b1);
      end else begin
        for (int i = 0; i < 110; i++) begin
          len = $urandom_range(0, 19);
          send_element(rand_element(), i == 0 || len == 0, 1'b1);
        end
      end
      drain();
    end

    repeat (60) @(posedge clk);
    $display("Run covered %0d coefficient settings, %0d results, %0d with overflow set.",
             phases, results, overflows);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
